// ===== src/nmea_sentence_framer_checker_defines.svh =====
// ----------------------------------------------------------------------------
// nmea sentence framer checker assertion macros
// clocked concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH

// property checked on every clock edge outside reset
`define NSFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define NSFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/nsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsfc_pkg
// shared constants, codes and types of the nmea sentence framer checker
// ----------------------------------------------------------------------------
`default_nettype none

package nsfc_pkg;

  localparam int TAG_LEN  = 5;
  localparam int BODY_MAX = 128;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 40;
  localparam int TAG_W  = TAG_LEN * 8;
  localparam int TC_W   = $clog2(TAG_LEN + 1);
  localparam int BC_W   = $clog2(BODY_MAX + 1);
  localparam int ST_W   = 3;

  localparam logic [CFG_W-1:0] EXPECTED_TAG_RST = 40'h4750474741;

  // ascii codes
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] HEX_ALPHA = 8'd65;
  localparam logic [BYTE_W-1:0] HEX_OFS_A = 8'd55;
  localparam logic [BYTE_W-1:0] HEX_OFS_D = 8'd48;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_WRONG_TAG = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_CSUM = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_FIX   = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [ST_W-1:0]   status;
    logic [BYTE_W-1:0] xor_sum;
  } nsfc_result_t;

endpackage

`default_nettype wire

// ===== src/nsfc_framer.sv =====
// ----------------------------------------------------------------------------
// nsfc_framer
// sentence state, running xor and status decision for one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module nsfc_framer
  import nsfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] byte_in,
  input  wire logic [CFG_W-1:0]  expected_tag,
  output nsfc_result_t           res
);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_TAG    = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  logic [1:0]        phase, phase_next;
  logic [TAG_W-1:0]  tag_shift, tag_shift_next;
  logic [TC_W-1:0]   tag_count, tag_count_next;
  logic [BC_W-1:0]   body_count, body_count_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;
  logic              star_seen, star_seen_next;
  logic              after_star, after_star_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic              time_empty, time_empty_next;

  logic [TAG_W-1:0]  tag_ref;
  logic [BYTE_W-1:0] hex_val;
  logic [BYTE_W-1:0] chk;
  logic              pos_one;

  function automatic logic [BYTE_W-1:0] hex_value(input logic [BYTE_W-1:0] b);
    hex_value = b - ((b >= HEX_ALPHA) ? HEX_OFS_A : HEX_OFS_D);
  endfunction

  assign tag_ref = TAG_W'(expected_tag);
  assign hex_val = hex_value(byte_in);
  assign chk     = running_xor - {high_nibble, 4'b0000} - hex_val;
  assign pos_one = star_seen ? (body_count == '0 && !after_star)
                             : (body_count == BC_W'(1));

  always_comb begin
    phase_next       = phase;
    tag_shift_next   = tag_shift;
    tag_count_next   = tag_count;
    body_count_next  = body_count;
    running_xor_next = running_xor;
    star_seen_next   = star_seen;
    after_star_next  = after_star;
    high_nibble_next = high_nibble;
    time_empty_next  = time_empty;
    res              = '0;

    if (step) begin
      case (phase)
        PH_TAG: begin
          if (byte_in == CH_DOLLAR) begin
            tag_shift_next   = '0;
            tag_count_next   = '0;
            running_xor_next = '0;
          end else begin
            tag_shift_next   = {tag_shift[TAG_W-BYTE_W-1:0], byte_in};
            running_xor_next = running_xor ^ byte_in;
            tag_count_next   = tag_count + TC_W'(1);
            if (tag_count == TC_W'(TAG_LEN - 1)) begin
              phase_next = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (byte_in == CH_DOLLAR && !(star_seen && after_star)) begin
            // restart half received sentence
            phase_next       = PH_TAG;
            tag_shift_next   = '0;
            tag_count_next   = '0;
            body_count_next  = '0;
            running_xor_next = '0;
            star_seen_next   = 1'b0;
            after_star_next  = 1'b0;
            high_nibble_next = '0;
            time_empty_next  = 1'b0;
          end else begin
            if (pos_one) begin
              time_empty_next = (byte_in == CH_COMMA);
            end
            if (!star_seen) begin
              if (byte_in == CH_STAR) begin
                star_seen_next  = 1'b1;
                after_star_next = 1'b0;
              end else begin
                running_xor_next = running_xor ^ byte_in;
                if (body_count < BC_W'(BODY_MAX)) begin
                  body_count_next = body_count + BC_W'(1);
                end
              end
            end else if (!after_star) begin
              high_nibble_next = hex_val[3:0];
              after_star_next  = 1'b1;
            end else begin
              res.valid   = 1'b1;
              res.xor_sum = running_xor;
              if (tag_shift != tag_ref) begin
                res.status = ST_WRONG_TAG;
              end else if (body_count > BC_W'(BODY_MAX - 3)) begin
                res.status = ST_OVERFLOW;
              end else if (chk != '0) begin
                res.status = ST_BAD_CSUM;
              end else if (time_empty_next) begin
                res.status = ST_NO_FIX;
              end else begin
                res.status = ST_OK;
              end
              phase_next = PH_SEARCH;
            end
          end
        end
        default: begin
          phase_next = PH_SEARCH;
          if (byte_in == CH_DOLLAR) begin
            phase_next       = PH_TAG;
            tag_shift_next   = '0;
            tag_count_next   = '0;
            body_count_next  = '0;
            running_xor_next = '0;
            star_seen_next   = 1'b0;
            after_star_next  = 1'b0;
            high_nibble_next = '0;
            time_empty_next  = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEARCH;
      tag_shift   <= '0;
      tag_count   <= '0;
      body_count  <= '0;
      running_xor <= '0;
      star_seen   <= 1'b0;
      after_star  <= 1'b0;
      high_nibble <= '0;
      time_empty  <= 1'b0;
    end else begin
      phase       <= phase_next;
      tag_shift   <= tag_shift_next;
      tag_count   <= tag_count_next;
      body_count  <= body_count_next;
      running_xor <= running_xor_next;
      star_seen   <= star_seen_next;
      after_star  <= after_star_next;
      high_nibble <= high_nibble_next;
      time_empty  <= time_empty_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/nmea_sentence_framer_checker.sv =====
// path: a byte is taken into the input register at its accepting edge, the
//   framer works on it combinationally once the output register can advance,
//   and its status request, if any, is then captured in the output register
// throughput: one byte per cycle while the status output is not stalled; the
//   single pass over the framer state is the only loop
// reset: rst is synchronous, clears all control state and reloads the tag
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker
// frames $tag body *hh sentences and reports one status request per sentence
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_framer_checker_defines.svh"

module nmea_sentence_framer_checker
  import nsfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // byte input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] rx_byte,
  // status output channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ST_W-1:0]        status,
  output logic [BYTE_W-1:0]      computed_xor,
  // expected tag write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic              in_q_valid;
  logic [BYTE_W-1:0] byte_q;
  logic [CFG_W-1:0]  expected_tag;
  logic              advance;
  logic              step;
  nsfc_result_t      res;

  // the output register can take a new result when empty or being drained
  assign advance  = !out_valid || !out_stall;
  // the input register only holds when its byte cannot move on
  assign in_stall = in_q_valid && !advance;
  assign step     = in_q_valid && advance;

  // configuration is accepted at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_tag <= EXPECTED_TAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      expected_tag <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

  // sentence state and status decision
  nsfc_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .byte_in      (byte_q),
    .expected_tag (expected_tag),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      status       <= res.status;
      computed_xor <= res.xor_sum;
    end
  end

  // a result is only produced on a step
  `NSFC_ASSERT_IMP(a_res_on_step, res.valid, step, "result without a step")
  // input stalls only behind a full and stalled output register
  `NSFC_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stall without cause")
  // a held input byte is not lost or changed
  `NSFC_ASSERT(a_in_hold, (in_q_valid && !advance) |=> (in_q_valid && $stable(byte_q)),
    "held input byte lost")
  // reported status stays within the defined codes
  `NSFC_ASSERT_IMP(a_status_range, out_valid, status <= ST_OVERFLOW, "status code out of range")

endmodule

`default_nettype wire
